@@ hw/rtl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue package
// Operation codes, cell commands and the types shared by the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned WordWidth    = 32;
  localparam int unsigned OpWidth      = 3;

  typedef enum logic [OpWidth-1:0] {
    OpPushFront = 3'd0,
    OpPushBack  = 3'd1,
    OpPopFront  = 3'd2,
    OpPopBack   = 3'd3,
    OpPeekFront = 3'd4,
    OpPeekBack  = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    CmdHold,
    CmdShiftIn,
    CmdAppend,
    CmdShiftOut,
    CmdDropTail
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e             cmd;
    logic [WordWidth-1:0]  word;
  } cell_ctl_t;

  typedef struct packed {
    logic                  occ;
    logic [WordWidth-1:0]  data;
  } cell_link_t;

endpackage

`default_nettype wire

@@ hw/rtl/deq_cell.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue cell
// Holds one word and its occupied flag, and shifts with its neighbours.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_cell
  import deq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctl_t  ctl_i,
  input  cell_link_t left_i,
  input  cell_link_t right_i,
  output cell_link_t state_o,
  output logic       tail_o
);

  logic                 occ_q, occ_d;
  logic [WordWidth-1:0] data_q, data_d;

  always_comb begin
    occ_d  = occ_q;
    data_d = data_q;
    unique case (ctl_i.cmd)
      CmdShiftIn: begin
        occ_d  = left_i.occ;
        data_d = left_i.data;
      end
      CmdAppend: begin
        if (!occ_q && left_i.occ) begin
          occ_d  = 1'b1;
          data_d = ctl_i.word;
        end
      end
      CmdShiftOut: begin
        occ_d  = right_i.occ;
        data_d = right_i.data;
      end
      CmdDropTail: begin
        if (occ_q && !right_i.occ) begin
          occ_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign state_o.occ  = occ_q;
  assign state_o.data = data_q;
  assign tail_o       = occ_q && !right_i.occ;

endmodule

`default_nettype wire

@@ hw/rtl/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue
// A deque of signed 32-bit words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// The deque takes one operation per clock cycle and gives one result for each,
// in the cycle after the transfer, from an output register; a new operation is
// taken whenever that register is empty or its result is being transferred.
// The words sit in a row of Depth cells, the front word always in the first
// cell, so a push or pop at the front shifts the whole row by one place, and
// the back word is found by the cell whose right neighbour is empty. A push on
// a full deque is refused and flagged; a pop or peek on an empty deque returns
// all ones with result_valid_o low.
`default_nettype none

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int unsigned Depth = DefaultDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [OpWidth-1:0]          op_i,
  input  logic signed [WordWidth-1:0] value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [WordWidth-1:0] result_value_o,
  output logic                        result_valid_o,
  output logic                        now_empty_o,
  output logic                        now_full_o,
  output logic                        push_refused_o
);

  cell_ctl_t            ctl;
  cell_link_t           cell_state [Depth];
  logic [Depth-1:0]     cell_tail;
  logic [WordWidth-1:0] back_word;
  logic                 accept, empty, full;
  logic                 push_op, pop_op, front_op, back_op;

  logic                 out_valid_q;
  logic [WordWidth-1:0] res_value_q, res_value_d;
  logic                 res_valid_q, res_valid_d;
  logic                 empty_q, empty_d;
  logic                 full_q, full_d;
  logic                 refused_q, refused_d;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    cell_link_t left_link, right_link;
    if (i == 0) begin : g_first
      assign left_link.occ  = 1'b1;
      assign left_link.data = value_i;
    end else begin : g_inner_left
      assign left_link = cell_state[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign right_link.occ  = 1'b0;
      assign right_link.data = '0;
    end else begin : g_inner_right
      assign right_link = cell_state[i+1];
    end
    deq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .left_i  (left_link),
      .right_i (right_link),
      .state_o (cell_state[i]),
      .tail_o  (cell_tail[i])
    );
  end

  always_comb begin
    back_word = '0;
    for (int i = 0; i < Depth; i++) begin
      back_word = back_word | ({WordWidth{cell_tail[i]}} & cell_state[i].data);
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign empty      = !cell_state[0].occ;
  assign full       = cell_state[Depth-1].occ;

  always_comb begin
    push_op  = 1'b0;
    pop_op   = 1'b0;
    front_op = 1'b0;
    back_op  = 1'b0;
    ctl.cmd  = CmdHold;
    ctl.word = value_i;
    unique case (op_i)
      OpPushFront: begin
        push_op = 1'b1;
        if (accept && !full) ctl.cmd = CmdShiftIn;
      end
      OpPushBack: begin
        push_op = 1'b1;
        if (accept && !full) ctl.cmd = CmdAppend;
      end
      OpPopFront: begin
        pop_op   = 1'b1;
        front_op = 1'b1;
        if (accept && !empty) ctl.cmd = CmdShiftOut;
      end
      OpPopBack: begin
        pop_op  = 1'b1;
        back_op = 1'b1;
        if (accept && !empty) ctl.cmd = CmdDropTail;
      end
      OpPeekFront: front_op = 1'b1;
      OpPeekBack:  back_op  = 1'b1;
      default: begin
      end
    endcase
  end

  always_comb begin
    res_value_d = '1;
    res_valid_d = 1'b0;
    refused_d   = push_op && full;
    empty_d     = empty;
    full_d      = full;
    if (!empty && front_op) begin
      res_value_d = cell_state[0].data;
      res_valid_d = 1'b1;
    end else if (!empty && back_op) begin
      res_value_d = back_word;
      res_valid_d = 1'b1;
    end
    if (push_op && !full) begin
      empty_d = 1'b0;
      full_d  = cell_state[Depth-2].occ;
    end else if (pop_op && !empty) begin
      empty_d = !cell_state[1].occ;
      full_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_value_q <= res_value_d;
      res_valid_q <= res_valid_d;
      empty_q     <= empty_d;
      full_q      <= full_d;
      refused_q   <= refused_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_value_q;
  assign result_valid_o = res_valid_q;
  assign now_empty_o    = empty_q;
  assign now_full_o     = full_q;
  assign push_refused_o = refused_q;

endmodule

`default_nettype wire

@@ hw/rtl/deq_checker.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue checker
// Port-level properties of the deque, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_checker
  import deq_pkg::*;
(
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic signed [WordWidth-1:0] result_value_o,
  input logic                        result_valid_o,
  input logic                        now_empty_o,
  input logic                        now_full_o,
  input logic                        push_refused_o
);

  // Every input transfer leaves a result waiting in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("No result after an input transfer.");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_value_o))
    else $error("Stalled result changed.");

  a_refused_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && push_refused_o |-> now_full_o && !result_valid_o)
    else $error("Refused push without a full deque.");

  a_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_valid_o |-> result_value_o == -32'sd1)
    else $error("Result without a word is not all ones.");

  a_empty_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(now_empty_o && now_full_o))
    else $error("Deque reported both empty and full.");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

`default_nettype wire

@@ tb/deque_checker.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue checker
// Watches both channels of the deque, keeps its own ring of words with a
// front index and an occupancy count, and compares every result transfer
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module deque_checker
  import deq_pkg::*;
#(
  parameter int unsigned Depth = DefaultDepth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [OpWidth-1:0]   op_i,
  input  logic [WordWidth-1:0] value_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [WordWidth-1:0] result_value_i,
  input  logic                 result_valid_i,
  input  logic                 now_empty_i,
  input  logic                 now_full_i,
  input  logic                 push_refused_i,
  output int                   errors_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WordWidth-1:0] value;
    logic                 valid;
    logic                 empty;
    logic                 full;
    logic                 refused;
  } deq_outcome_t;

  logic [WordWidth-1:0] ring_words [Depth];
  int unsigned          front_pos = 0;
  int unsigned          fill      = 0;
  deq_outcome_t         awaited_results [$];
  int                   mismatches = 0;

  task automatic apply_deque_op(input logic [OpWidth-1:0] op,
                                input logic [WordWidth-1:0] word,
                                output deq_outcome_t res);
    int unsigned back_pos;
    back_pos    = (front_pos + fill + Depth - 1) % Depth;
    res         = '0;
    res.value   = '1;
    case (op)
      OpPushFront: begin
        if (fill == Depth) begin
          res.refused = 1'b1;
        end else begin
          front_pos = (front_pos + Depth - 1) % Depth;
          ring_words[front_pos] = word;
          fill++;
        end
      end
      OpPushBack: begin
        if (fill == Depth) begin
          res.refused = 1'b1;
        end else begin
          ring_words[(front_pos + fill) % Depth] = word;
          fill++;
        end
      end
      OpPopFront: begin
        if (fill != 0) begin
          res.value = ring_words[front_pos];
          res.valid = 1'b1;
          front_pos = (front_pos + 1) % Depth;
          fill--;
        end
      end
      OpPopBack: begin
        if (fill != 0) begin
          res.value = ring_words[back_pos];
          res.valid = 1'b1;
          fill--;
        end
      end
      OpPeekFront: begin
        if (fill != 0) begin
          res.value = ring_words[front_pos];
          res.valid = 1'b1;
        end
      end
      OpPeekBack: begin
        if (fill != 0) begin
          res.value = ring_words[back_pos];
          res.valid = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.empty = (fill == 0);
    res.full  = (fill == Depth);
  endtask

  task automatic compare_field(input string name, input logic [WordWidth-1:0] want,
                               input logic [WordWidth-1:0] got);
    if (got !== want) begin
      $error("%s: expected %08h, got %08h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    deq_outcome_t oldest;
    deq_outcome_t fresh;
    if (!rst_ni) begin
      front_pos = 0;
      fill      = 0;
      awaited_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with no prediction outstanding");
          mismatches++;
        end else begin
          oldest = awaited_results.pop_front();
          compare_field("result_value", oldest.value, result_value_i);
          compare_field("result_valid", WordWidth'(oldest.valid),
                        WordWidth'(result_valid_i));
          compare_field("now_empty", WordWidth'(oldest.empty), WordWidth'(now_empty_i));
          compare_field("now_full", WordWidth'(oldest.full), WordWidth'(now_full_i));
          compare_field("push_refused", WordWidth'(oldest.refused),
                        WordWidth'(push_refused_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_deque_op(op_i, value_i, fresh);
        awaited_results.push_back(fresh);
      end
    end
    errors_o  <= mismatches;
    pending_o <= awaited_results.size();
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives directed and random operations into the deque under varying idle
// patterns on both channels, with a long receiver hold-off in every phase,
// and reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import deq_pkg::*;

  localparam int unsigned           ItemsPerPhase = 600;
  localparam int unsigned           HoldCycles    = 48;
  localparam logic [OpWidth-1:0]    OpSpareA      = 3'd6;
  localparam logic [OpWidth-1:0]    OpSpareB      = 3'd7;

  typedef enum int unsigned {MixFill, MixDrain, MixEven} mix_e;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic [OpWidth-1:0]          op_i        = '0;
  logic [WordWidth-1:0]        value_i     = '0;
  logic                        out_ready_i = 1'b0;
  logic                        in_ready_o;
  logic                        out_valid_o;
  logic signed [WordWidth-1:0] result_value_o;
  logic                        result_valid_o;
  logic                        now_empty_o;
  logic                        now_full_o;
  logic                        push_refused_o;
  int                          errors;
  int                          pending;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_request  = 1'b0;

  always #5 clk_i = ~clk_i;

  double_ended_queue u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .op_i,
    .value_i,
    .out_valid_o,
    .out_ready_i,
    .result_value_o,
    .result_valid_o,
    .now_empty_o,
    .now_full_o,
    .push_refused_o
  );

  deque_checker u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i     (in_ready_o),
    .op_i,
    .value_i,
    .out_valid_i    (out_valid_o),
    .out_ready_i,
    .result_value_i (result_value_o),
    .result_valid_i (result_valid_o),
    .now_empty_i    (now_empty_o),
    .now_full_i     (now_full_o),
    .push_refused_i (push_refused_o),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  function automatic logic [OpWidth-1:0] pick_op(input mix_e mix);
    int unsigned roll;
    int unsigned push_pct;
    roll     = $urandom_range(99);
    push_pct = (mix == MixFill) ? 70 : (mix == MixDrain) ? 22 : 48;
    if (roll < 3) return $urandom_range(1) ? OpSpareA : OpSpareB;
    if (roll < 3 + push_pct) return $urandom_range(1) ? OpPushFront : OpPushBack;
    case ($urandom_range(3))
      0:       return OpPopFront;
      1:       return OpPopBack;
      2:       return OpPeekFront;
      default: return OpPeekBack;
    endcase
  endfunction

  function automatic logic [WordWidth-1:0] pick_word();
    if ($urandom_range(99) < 12) begin
      case ($urandom_range(3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom();
  endfunction

  // Called at a rising edge; returns at the edge where the transfer happens.
  task automatic send(input logic [OpWidth-1:0] op, input logic [WordWidth-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    value_i    <= word;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin : receiver
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : stimulus
    mix_e mix;
    mix = MixEven;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(OpPopFront, $urandom());
    send(OpPopBack, $urandom());
    send(OpPeekFront, $urandom());
    send(OpPeekBack, $urandom());
    send(OpSpareA, $urandom());
    send(OpSpareB, $urandom());
    send(OpPushFront, 32'h8000_0000);
    send(OpPushBack, 32'h7fff_ffff);
    send(OpPeekFront, $urandom());
    send(OpPeekBack, $urandom());
    send(OpPushFront, 32'hffff_ffff);
    send(OpPushBack, 32'h0000_0000);
    send(OpPopBack, $urandom());
    send(OpPopFront, $urandom());
    send(OpPopFront, $urandom());
    send(OpPopBack, $urandom());
    send(OpPopFront, $urandom());
    send(OpPushBack, 32'haaaa_aaaa);
    send(OpPushFront, 32'h5555_5555);
    send(OpPeekBack, $urandom());
    send(OpSpareB, $urandom());
    send(OpPopBack, $urandom());
    send(OpPopBack, $urandom());
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 53 : 0;
      recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 16 : 0;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (n % 40 == 0) mix = mix_e'($urandom_range(2));
        if (n == ItemsPerPhase / 2) hold_request = 1'b1;
        send(pick_op(mix), pick_word());
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
